// ===== rtl/waas_pkg.sv =====
// Package: shared types, constants and state encodings for the window average angle sensor.
package waas_pkg;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SQUARE_COEF = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LINEAR_COEF = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_COEF = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WOBBLE      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPORT      = 3'd5;

    localparam logic [8:0]  WINDOW_RST = 9'd125;
    localparam logic [15:0] SQUARE_RST = 16'd1481;
    localparam logic [15:0] LINEAR_RST = 16'd10834;
    localparam logic [15:0] OFFSET_RST = 16'd426;
    localparam logic [8:0]  WOBBLE_RST = 9'd2;
    localparam logic [15:0] REPORT_RST = 16'd819;

    localparam logic [12:0] DEGREE_FULL = 13'd5760;

    typedef struct packed {
        logic [15:0] sample;
        logic        force_report;
    } t_in;

    typedef struct packed {
        logic [15:0] avg_volts;
        logic [12:0] degree;
        logic        jumped;
        logic        report;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } t_back_state;

endpackage

// ===== rtl/window_average_angle_sensor_top.sv =====
// Top level: window average angle sensor with configuration registers.
//
// One voltage sample per request. While the window fills (after reset or
// any window_size write) samples are absorbed without result, one per cycle.
// Once full, each request runs through a queue into a back end that swaps the
// oldest ring entry, divides the running sum by the window size with a
// restoring divider (one quotient bit per cycle), evaluates the quadratic
// curve with one registered multiply per cycle, then flags jump and report.
// A result occupies the back end through its read, divide, multiply and
// output states; the two-entry queue lets new requests arrive while one
// works.
// Configure only while idle.
module window_average_angle_sensor_top #(
    parameter int WINDOW_MAX  = waas_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  waas_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output waas_pkg::t_out                      o_data,
    input  logic                                i_cfg_we,
    input  logic [waas_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [waas_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import waas_pkg::*;

    logic [8:0]         r_win;
    logic signed [15:0] r_sq, r_lin, r_off;
    logic [8:0]         r_wob;
    logic [15:0]        r_rep;
    logic [8:0]         eff_n;
    logic               restart;
    logic               q_full, q_empty, push, pop, fill_write, win_full;
    t_in                q_out;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WINDOW_RST;
            r_sq  <= SQUARE_RST;
            r_lin <= LINEAR_RST;
            r_off <= OFFSET_RST;
            r_wob <= WOBBLE_RST;
            r_rep <= REPORT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_SIZE: r_win <= i_cfg_data[8:0];
                REG_SQUARE_COEF: r_sq  <= i_cfg_data;
                REG_LINEAR_COEF: r_lin <= i_cfg_data;
                REG_OFFSET_COEF: r_off <= i_cfg_data;
                REG_WOBBLE:      r_wob <= i_cfg_data[8:0];
                REG_REPORT:      r_rep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == REG_WINDOW_SIZE);
    // clamp window size: zero acts as one, above the ring depth as the depth
    assign eff_n = (r_win == 9'd0) ? 9'd1 :
                   ({23'd0, r_win} > WINDOW_MAX) ? 9'(WINDOW_MAX) : r_win;

    waas_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_eff_n      (eff_n),
        .i_restart    (restart),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_fill_write (fill_write),
        .o_window_full(win_full)
    );

    waas_queue #(.WIDTH($bits(t_in))) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (i_data),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_data (q_out)
    );

    waas_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (restart),
        .i_eff_n      (eff_n),
        .i_sq_coef    (r_sq),
        .i_lin_coef   (r_lin),
        .i_off_coef   (r_off),
        .i_wobble     (r_wob),
        .i_rep_delta  (r_rep),
        .i_fill_write (fill_write & ~win_full),
        .i_fill_sample(i_data.sample),
        .i_q_empty    (q_empty),
        .i_q_data     (q_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );
endmodule

// ===== rtl/waas_ram.sv =====
// Generic single-port-write RAM with registered read.
module waas_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/waas_queue.sv =====
// Two-entry queue carrying requests from the front part to the back part.
module waas_queue #(
    parameter int WIDTH = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_slot[r_rp];
endmodule

// ===== rtl/waas_front.sv =====
// Front part: accept samples, flag them for the ring while the window fills, queue the rest.
module waas_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [8:0]    i_eff_n,
    input  logic          i_restart,
    input  logic          i_q_full,
    output logic          o_push,
    output logic          o_fill_write,
    output logic          o_window_full
);
    import waas_pkg::*;

    logic [8:0] r_fill;
    logic       r_full;
    logic       acc;

    assign o_stall       = r_full & i_q_full;
    assign acc           = i_valid & ~o_stall;
    assign o_push        = acc & r_full;
    assign o_fill_write  = acc & ~r_full;
    assign o_window_full = r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fill <= '0;
            r_full <= 1'b0;
        end else if (o_fill_write) begin
            r_fill <= r_fill + 9'd1;
            if (r_fill + 9'd1 >= i_eff_n) begin
                r_full <= 1'b1;
            end
        end
    end
endmodule

// ===== rtl/waas_back.sv =====
// Back part: ring update, divide by window size, curve, clamp, jump and report.
module waas_back #(
    parameter int WINDOW_MAX  = waas_pkg::WINDOW_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic [8:0]                          i_eff_n,
    input  logic signed [15:0]                  i_sq_coef,
    input  logic signed [15:0]                  i_lin_coef,
    input  logic signed [15:0]                  i_off_coef,
    input  logic [8:0]                          i_wobble,
    input  logic [15:0]                         i_rep_delta,
    input  logic                                i_fill_write,
    input  logic [waas_pkg::SAMPLE_BITS_DEF-1:0] i_fill_sample,
    input  logic                                i_q_empty,
    input  waas_pkg::t_in                       i_q_data,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_stall,
    output waas_pkg::t_out                      o_data
);
    import waas_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int SUMW = SAMPLE_BITS + AW + 1;
    localparam int FRAC = SAMPLE_BITS - 2;
    localparam int PW   = 2 * SAMPLE_BITS + 20;
    localparam int CW   = $clog2(SUMW + 1);

    t_back_state r_st, n_st;
    logic [AW-1:0]          r_ptr;
    logic [SUMW-1:0]        r_sum;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic                   r_force;
    logic [SUMW-1:0]        r_rem;
    logic [SUMW-1:0]        r_quo;
    logic [CW-1:0]          r_cnt;
    logic [1:0]             r_mstep;
    logic signed [PW-1:0]   r_t;
    logic [2*SAMPLE_BITS-1:0] r_prod;
    logic [8:0]             r_prior;
    logic [15:0]            r_last;
    logic                   r_rep_once;
    logic                   r_ovalid;
    t_out                   r_out;

    logic [SAMPLE_BITS-1:0] old_smp;
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [AW-1:0]          idx;
    logic [AW:0]            idx_inc;
    logic [AW-1:0]          nxt_ptr;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SUMW:0]          trial;
    logic signed [PW-1:0]   lim;
    logic [12:0]            d16;
    logic [12:0]            prev16;
    logic [12:0]            ddiff;
    logic                   jmp;
    logic [15:0]            vdiff;
    logic                   rep;

    assign idx     = ({1'b0, r_ptr} < (AW+1)'(i_eff_n)) ? r_ptr : '0;
    assign idx_inc = {1'b0, idx} + (AW+1)'(1);
    assign nxt_ptr = ((AW+1)'(i_eff_n) <= idx_inc) ? '0 : idx_inc[AW-1:0];

    assign ram_we    = i_fill_write || (r_st == ST_DIV && r_cnt == '0);
    assign ram_addr  = idx;
    assign ram_wdata = i_fill_write ? i_fill_sample : r_smp;

    waas_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW_MAX)) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_addr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_addr),
        .o_rdata(old_smp)
    );

    assign avg    = r_quo[SAMPLE_BITS-1:0];
    assign trial  = {r_rem, r_quo[SUMW-1]} - {{(SUMW-8){1'b0}}, i_eff_n};
    assign lim    = PW'(360) <<< (FRAC + 8);
    assign prev16 = {r_prior, 4'd0};
    assign d16    = (r_t > lim || r_t < -lim) ? DEGREE_FULL :
                    (r_t < 0) ? 13'd0 : 13'(r_t >>> (FRAC + 4));
    assign ddiff  = (d16 > prev16) ? d16 - prev16 : prev16 - d16;
    assign jmp    = ddiff > {i_wobble, 4'd0};
    assign vdiff  = (avg[15:0] > r_last) ? avg[15:0] - r_last : r_last - avg[15:0];
    assign rep    = vdiff > i_rep_delta || jmp || r_force || !r_rep_once;

    assign o_pop   = (r_st == ST_IDLE) && !i_q_empty;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (!i_q_empty) n_st = ST_READ;
            ST_READ: n_st = ST_DIV;
            ST_DIV:  if (r_cnt == CW'(SUMW)) n_st = ST_MUL;
            ST_MUL:  if (r_mstep == 2'd3) n_st = ST_SUM;
            ST_SUM:  if (!r_ovalid || !i_stall) n_st = ST_OUT;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_ptr      <= '0;
            r_sum      <= '0;
            r_prior    <= '0;
            r_last     <= '0;
            r_rep_once <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_ovalid && !i_stall && r_st != ST_SUM) begin
                r_ovalid <= 1'b0;
            end
            if (i_restart) begin
                r_ptr <= '0;
                r_sum <= '0;
            end else if (i_fill_write) begin
                r_ptr <= nxt_ptr;
                r_sum <= r_sum + SUMW'(i_fill_sample);
            end
            case (r_st)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_smp   <= i_q_data.sample[SAMPLE_BITS-1:0];
                        r_force <= i_q_data.force_report;
                    end
                end
                ST_READ: begin
                    r_cnt <= '0;
                end
                ST_DIV: begin
                    // first cycle: update ring and sum; then restoring divide
                    if (r_cnt == '0) begin
                        r_sum <= r_sum + SUMW'(r_smp) - SUMW'(old_smp);
                        r_quo <= r_sum + SUMW'(r_smp) - SUMW'(old_smp);
                        r_rem <= '0;
                        r_ptr <= nxt_ptr;
                    end else begin
                        if (!trial[SUMW]) begin
                            r_rem <= trial[SUMW-1:0];
                            r_quo <= {r_quo[SUMW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[SUMW-2:0], r_quo[SUMW-1]};
                            r_quo <= {r_quo[SUMW-2:0], 1'b0};
                        end
                    end
                    r_cnt   <= r_cnt + CW'(1);
                    r_mstep <= '0;
                end
                ST_MUL: begin
                    // one multiply per step, registered
                    case (r_mstep)
                        2'd0: begin
                            r_prod <= avg * avg;
                            r_t    <= PW'(i_off_coef) <<< FRAC;
                        end
                        2'd1: begin
                            r_t <= r_t + PW'($signed({1'b0, r_prod >> FRAC}))
                                   * PW'(i_sq_coef);
                        end
                        2'd2: begin
                            r_t <= r_t + PW'($signed({1'b0, avg})) * PW'(i_lin_coef);
                        end
                        default: ;
                    endcase
                    r_mstep <= r_mstep + 2'd1;
                end
                ST_SUM: begin
                    if (!r_ovalid || !i_stall) begin
                        r_out.avg_volts    <= 16'(avg);
                        r_out.degree       <= d16;
                        r_out.jumped       <= jmp;
                        r_out.report       <= rep;
                        r_ovalid           <= 1'b1;
                        r_prior            <= d16[12:4];
                        if (rep) begin
                            r_last     <= 16'(avg);
                            r_rep_once <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
